### hdl/assert_macros.svh
// Assertion macros used by the port checker.
// Needs a clk and an active-low rst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define XCTR_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("port assertion failed");

// next-cycle implication
`define XCTR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("port assertion failed");

`endif

### hdl/xctr_pkg.sv
// Shared types and constants of the XXTEA counter random byte unit.
// No dependencies.
`default_nettype none

package xctr_pkg;

    localparam logic [31:0] XX_DELTA = 32'h9E37_79B9;
    localparam int          ADDR_W   = 6;

    // register indexes (address bits 5:3)
    localparam logic [2:0] REG_KEY_LOW     = 3'd0;
    localparam logic [2:0] REG_KEY_HIGH    = 3'd1;
    localparam logic [2:0] REG_WHITEN_LOW  = 3'd2;
    localparam logic [2:0] REG_WHITEN_HIGH = 3'd3;
    localparam logic [2:0] REG_START_LOW   = 3'd4;
    localparam logic [2:0] REG_START_HIGH  = 3'd5;

    typedef struct packed {
        logic       load_start;   // reseed: counter from start registers
        logic       refill_load;  // step counter, load cipher words
        logic       round_step;   // one word update of the cipher
        logic       finish;       // cipher words xor whitening into keystream
        logic       out_load;     // capture selected keystream byte
        logic [3:0] byte_sel;
    } cmd_t;

    typedef struct packed {
        logic round_done;         // current step is the last one
    } status_t;

endpackage

`default_nettype wire

### hdl/xctr_datapath.sv
// Datapath: counter, XXTEA word-serial cipher, keystream block, output byte.
// Depends on xctr_pkg.
`default_nettype none

module xctr_datapath #(
    parameter int ROUNDS = 19
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire xctr_pkg::cmd_t   cmd,
    output xctr_pkg::status_t     status,
    input  wire logic [127:0]     key,
    input  wire logic [127:0]     whiten,
    input  wire logic [127:0]     start,
    output logic [7:0]            rand_byte
);

    localparam int RW = $clog2(ROUNDS);

    logic [31:0]   ctr_reg [4];
    logic [31:0]   wrk_reg [4];
    logic [31:0]   ks_reg  [4];
    logic [31:0]   sum_reg;
    logic [1:0]    qtr_reg;
    logic [RW-1:0] rnd_reg;
    logic [7:0]    byte_reg;

    logic [31:0] key_w [4];
    logic [31:0] ctr0_inc;
    logic [31:0] ctr1_step;
    logic [31:0] sum_cur;
    logic [1:0]  key_sel;
    logic [31:0] mix_a;
    logic [31:0] mix_b;
    logic [31:0] new_word;
    logic [31:0] ks_word;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            key_w[i] = key[32*i +: 32];
        end
    end

    // counter step: word 0 up, borrow into word 1 on wrap
    assign ctr0_inc  = ctr_reg[0] + 32'd1;
    assign ctr1_step = (ctr0_inc == 32'd0) ? (ctr_reg[1] - 32'd1) : ctr_reg[1];

    // word 0 of the rotating set is updated; y is the next word, z the latest one
    assign sum_cur  = (qtr_reg == 2'd0) ? (sum_reg + xctr_pkg::XX_DELTA) : sum_reg;
    assign key_sel  = qtr_reg ^ sum_cur[3:2];
    assign mix_a    = ((wrk_reg[3] >> 5) ^ (wrk_reg[1] << 2))
                    + ((wrk_reg[1] >> 3) ^ (wrk_reg[3] << 4));
    assign mix_b    = (sum_cur ^ wrk_reg[1]) + (key_w[key_sel] ^ wrk_reg[3]);
    assign new_word = wrk_reg[0] + (mix_a ^ mix_b);

    assign status.round_done = (rnd_reg == RW'(ROUNDS - 1)) && (qtr_reg == 2'd3);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
            begin
                ctr_reg[i] <= 32'd0;
            end
        end
        else if (cmd.load_start)
        begin
            for (int i = 0; i < 4; i++)
            begin
                ctr_reg[i] <= start[32*i +: 32];
            end
        end
        else if (cmd.refill_load)
        begin
            ctr_reg[0] <= ctr0_inc;
            ctr_reg[1] <= ctr1_step;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= 32'd0;
            qtr_reg <= 2'd0;
            rnd_reg <= '0;
        end
        else if (cmd.refill_load)
        begin
            sum_reg <= 32'd0;
            qtr_reg <= 2'd0;
            rnd_reg <= '0;
        end
        else if (cmd.round_step)
        begin
            sum_reg <= sum_cur;
            qtr_reg <= qtr_reg + 2'd1;
            if (qtr_reg == 2'd3)
            begin
                rnd_reg <= rnd_reg + RW'(1);
            end
        end
    end

    // after a whole number of rounds the rotation is back in word order
    always_ff @(posedge clk)
    begin
        if (cmd.refill_load)
        begin
            wrk_reg[0] <= ctr0_inc;
            wrk_reg[1] <= ctr1_step;
            wrk_reg[2] <= ctr_reg[2];
            wrk_reg[3] <= ctr_reg[3];
        end
        else if (cmd.round_step)
        begin
            wrk_reg[0] <= wrk_reg[1];
            wrk_reg[1] <= wrk_reg[2];
            wrk_reg[2] <= wrk_reg[3];
            wrk_reg[3] <= new_word;
        end
        if (cmd.finish)
        begin
            for (int i = 0; i < 4; i++)
            begin
                ks_reg[i] <= wrk_reg[i] ^ whiten[32*i +: 32];
            end
        end
        if (cmd.out_load)
        begin
            byte_reg <= ks_word[8*cmd.byte_sel[1:0] +: 8];
        end
    end

    assign ks_word   = ks_reg[cmd.byte_sel[3:2]];
    assign rand_byte = byte_reg;

endmodule

`default_nettype wire

### hdl/xctr_controller.sv
// Controller: request handshake, byte index, refill sequencing, output valid.
// Depends on xctr_pkg.
`default_nettype none

module xctr_controller #(
    parameter int MAX_REQUEST = 8
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic               mode,
    input  wire logic [3:0]         byte_count,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic                    last,
    output xctr_pkg::cmd_t          cmd,
    input  wire xctr_pkg::status_t  status
);

    localparam int REM_W = $clog2(MAX_REQUEST + 1);
    localparam int CMP_W = (REM_W > 4) ? REM_W : 4;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_EMIT   = 4'b0010,
        S_ROUND  = 4'b0100,
        S_FINISH = 4'b1000
    } state_t;

    state_t           state_reg, state_next;
    logic [4:0]       bidx_reg, bidx_next;
    logic [REM_W-1:0] rem_reg, rem_next;
    logic             out_valid_reg, out_valid_next;
    logic             last_reg, last_next;

    logic [CMP_W-1:0] cnt_ext;
    logic [REM_W-1:0] cnt_sat;

    assign cnt_ext = CMP_W'(byte_count);
    assign cnt_sat = (cnt_ext > CMP_W'(MAX_REQUEST)) ? REM_W'(MAX_REQUEST)
                                                     : REM_W'(cnt_ext);

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign last      = last_reg;

    always_comb
    begin
        state_next     = state_reg;
        bidx_next      = bidx_reg;
        rem_next       = rem_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (mode)
                    begin
                        cmd.load_start = 1'b1;
                        bidx_next      = 5'd16;
                    end
                    else if (byte_count != 4'd0)
                    begin
                        rem_next   = cnt_sat;
                        state_next = S_EMIT;
                    end
                end
            end
            S_EMIT:
            begin
                if (bidx_reg[4])
                begin
                    // block used up: step the counter and start the cipher
                    cmd.refill_load = 1'b1;
                    state_next      = S_ROUND;
                end
                else if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load   = 1'b1;
                    cmd.byte_sel   = bidx_reg[3:0];
                    out_valid_next = 1'b1;
                    last_next      = (rem_reg == REM_W'(1));
                    bidx_next      = bidx_reg + 5'd1;
                    rem_next       = rem_reg - REM_W'(1);
                    if (rem_reg == REM_W'(1))
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_ROUND:
            begin
                cmd.round_step = 1'b1;
                if (status.round_done)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                cmd.finish = 1'b1;
                bidx_next  = 5'd0;
                state_next = S_EMIT;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            bidx_reg      <= 5'd16;
            rem_reg       <= '0;
            out_valid_reg <= 1'b0;
            last_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            bidx_reg      <= bidx_next;
            rem_reg       <= rem_next;
            out_valid_reg <= out_valid_next;
            last_reg      <= last_next;
        end
    end

endmodule

`default_nettype wire

### hdl/xxtea_counter_random_bytes_unit.sv
// Top level of the XXTEA counter random byte unit: register port and glue.
// Depends on xctr_pkg, xctr_controller and xctr_datapath.
`default_nettype none

// Usage
//   Request channel (in_valid/in_ready, mode, byte_count): mode 0 asks for
//   byte_count bytes (saturated at MAX_REQUEST; zero gives nothing), mode 1
//   reloads the counter from the start registers and forces a refill.
//   Result channel (out_valid/out_ready, rand_byte, last): bytes come one
//   per item, last marks the final byte of a request.
//   Registers: six 64-bit registers at byte addresses 0, 8, .. 40 (key,
//   whitening, start counter, low halves first). Write only while idle.
// Timing
//   One request is handled at a time; in_ready is high only between
//   requests. A reseed or zero-count request leaves in_ready high.
//   Bytes from the current block come out back to back while the receiver is
//   ready. When the 16-byte block is used up, a refill runs first: the counter
//   is stepped and the cipher words loaded, then 4*ROUNDS word updates run, one
//   per cycle, then the words are whitened into the new keystream block.
// Reset and stall
//   Reset clears the counter and the registers and marks the block used up.
//   A stalled byte is held in the output register and the next byte waits
//   for it to be taken; a refill already started runs on during the stall.

module xxtea_counter_random_bytes_unit #(
    parameter int ROUNDS      = 19,
    parameter int MAX_REQUEST = 8
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [xctr_pkg::ADDR_W-1:0] paddr,
    input  wire logic [63:0]                 pwdata,
    output logic [63:0]                      prdata,
    output logic                             pready,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic                        mode,
    input  wire logic [3:0]                  byte_count,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [7:0]                       rand_byte,
    output logic                             last
);

    logic [63:0] key_low_reg, key_high_reg;
    logic [63:0] whiten_low_reg, whiten_high_reg;
    logic [63:0] start_low_reg, start_high_reg;

    logic [2:0] reg_idx;
    logic       cfg_wr;

    xctr_pkg::cmd_t    cmd;
    xctr_pkg::status_t status;

    // 64-bit registers on 8-byte steps; the low address bits select nothing
    assign reg_idx = paddr[5:3];
    assign cfg_wr  = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_low_reg     <= 64'd0;
            key_high_reg    <= 64'd0;
            whiten_low_reg  <= 64'd0;
            whiten_high_reg <= 64'd0;
            start_low_reg   <= 64'd0;
            start_high_reg  <= 64'd0;
        end
        else if (cfg_wr)
        begin
            unique case (reg_idx)
                xctr_pkg::REG_KEY_LOW:     key_low_reg     <= pwdata;
                xctr_pkg::REG_KEY_HIGH:    key_high_reg    <= pwdata;
                xctr_pkg::REG_WHITEN_LOW:  whiten_low_reg  <= pwdata;
                xctr_pkg::REG_WHITEN_HIGH: whiten_high_reg <= pwdata;
                xctr_pkg::REG_START_LOW:   start_low_reg   <= pwdata;
                xctr_pkg::REG_START_HIGH:  start_high_reg  <= pwdata;
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            xctr_pkg::REG_KEY_LOW:     prdata = key_low_reg;
            xctr_pkg::REG_KEY_HIGH:    prdata = key_high_reg;
            xctr_pkg::REG_WHITEN_LOW:  prdata = whiten_low_reg;
            xctr_pkg::REG_WHITEN_HIGH: prdata = whiten_high_reg;
            xctr_pkg::REG_START_LOW:   prdata = start_low_reg;
            xctr_pkg::REG_START_HIGH:  prdata = start_high_reg;
            default:                   prdata = 64'd0;
        endcase
    end

    xctr_controller #(
        .MAX_REQUEST (MAX_REQUEST)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .mode       (mode),
        .byte_count (byte_count),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .last       (last),
        .cmd        (cmd),
        .status     (status)
    );

    xctr_datapath #(
        .ROUNDS (ROUNDS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .key       ({key_high_reg, key_low_reg}),
        .whiten    ({whiten_high_reg, whiten_low_reg}),
        .start     ({start_high_reg, start_low_reg}),
        .rand_byte (rand_byte)
    );

endmodule

`default_nettype wire

### hdl/xctr_checker.sv
// Port-level checker for the random byte unit, bound to the top level.
// Depends on assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module xctr_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_ready,
    input wire logic       mode,
    input wire logic [3:0] byte_count,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [7:0] rand_byte,
    input wire logic       last
);

    // a stalled byte holds
    `XCTR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(rand_byte) && $stable(last))

    // mid-request bytes are pending only while the request is still busy
    `XCTR_ASSERT_SAME(a_busy_mid, out_valid && !last, !in_ready)

    // reseed and empty get leave in_ready high
    `XCTR_ASSERT_NEXT(a_quick, in_valid && in_ready && (mode || byte_count == 4'd0), in_ready)

    // a real get keeps the request side busy
    `XCTR_ASSERT_NEXT(a_get_busy, in_valid && in_ready && !mode && byte_count != 4'd0, !in_ready)

endmodule

bind xxtea_counter_random_bytes_unit xctr_checker u_xctr_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .mode       (mode),
    .byte_count (byte_count),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .rand_byte  (rand_byte),
    .last       (last)
);

`default_nettype wire
